// ===== rtl/triangle_span_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle span generator
// Shared property forms used by the top level's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SPAN_GENERATOR_UNIT_DEFINES_SVH
`define TRIANGLE_SPAN_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle span generator package
// Shared widths, defaults, the walker state type and the queue status.
// ----------------------------------------------------------------------------
package tsg_pkg;

  // Fixed field widths.
  localparam int unsigned ROW_BITS    = 6;
  localparam int unsigned COLOUR_BITS = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned X_BITS_DEF    = 10;
  localparam int unsigned TILE_ROWS_DEF = 64;

  // Triangle queue between front and back; depth is a power of two so that
  // the pointers wrap on their own.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Edge walker sequencer states.
  typedef enum logic [2:0] {
    WS_IDLE,
    WS_SETUP,
    WS_CHECK,
    WS_EMIT,
    WS_STEP,
    WS_FINAL
  } walk_state_e;

  // Fill status of the triangle queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/tsg_front.sv =====
// ----------------------------------------------------------------------------
// Triangle span generator front end
// Holds one incoming triangle, clamps its rows to the tile, sorts the
// vertices top to bottom and folds a flat triangle into a single span.
// ----------------------------------------------------------------------------
module tsg_front
  import tsg_pkg::*;
#(
  parameter int unsigned X_BITS    = X_BITS_DEF,
  parameter int unsigned TILE_ROWS = TILE_ROWS_DEF,
  localparam int unsigned IN_W     = 3 * (X_BITS + ROW_BITS) + COLOUR_BITS,
  localparam int unsigned TASK_W   = 3 * X_BITS + 3 * ROW_BITS + COLOUR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IN_W-1:0]   in_data_i,
  output logic              task_valid_o,
  input  logic              task_ready_i,
  output logic [TASK_W-1:0] task_data_o
);

  localparam int unsigned VW = X_BITS + ROW_BITS;
  localparam logic [ROW_BITS-1:0] ROW_MAX = ROW_BITS'(TILE_ROWS - 1);

  logic              valid_q;
  logic [IN_W-1:0]   in_q;
  logic [X_BITS-1:0] x0, x1, x2;
  logic [ROW_BITS-1:0] y0, y1, y2;
  logic [X_BITS-1:0] ax, bx, cx, bx_o, cx_o, lo, hi;
  logic [ROW_BITS-1:0] ay, by, cy;

  function automatic logic [ROW_BITS-1:0] clamp_row(input logic [ROW_BITS-1:0] r);
    return (r > ROW_MAX) ? ROW_MAX : r;
  endfunction

  // Single holding register; a new triangle enters as the old one leaves.
  assign in_ready_o   = !valid_q || task_ready_i;
  assign task_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Unpack the vertices and clamp rows to the tile.
  assign x0 = in_q[0 +: X_BITS];
  assign y0 = clamp_row(in_q[X_BITS +: ROW_BITS]);
  assign x1 = in_q[VW +: X_BITS];
  assign y1 = clamp_row(in_q[VW + X_BITS +: ROW_BITS]);
  assign x2 = in_q[2 * VW +: X_BITS];
  assign y2 = clamp_row(in_q[2 * VW + X_BITS +: ROW_BITS]);

  // Sort into top (A), middle (B) and bottom (C) with a fixed tie order.
  always_comb begin
    if (y0 < y1) begin
      if (y1 < y2) begin
        ax = x0; ay = y0; bx = x1; by = y1; cx = x2; cy = y2;
      end else if (y2 < y0) begin
        ax = x2; ay = y2; bx = x0; by = y0; cx = x1; cy = y1;
      end else begin
        ax = x0; ay = y0; bx = x2; by = y2; cx = x1; cy = y1;
      end
    end else begin
      if (y1 < y2) begin
        if (y2 < y0) begin
          ax = x1; ay = y1; bx = x2; by = y2; cx = x0; cy = y0;
        end else begin
          ax = x1; ay = y1; bx = x0; by = y0; cx = x2; cy = y2;
        end
      end else begin
        ax = x2; ay = y2; bx = x1; by = y1; cx = x0; cy = y0;
      end
    end
  end

  // A flat triangle becomes one span from the least to the greatest x. It is
  // carried in the B and C slots so that the back end treats it like the
  // closing span of a flat-bottomed triangle.
  always_comb begin
    lo = ax;
    hi = ax;
    if (bx < lo) lo = bx;
    if (cx < lo) lo = cx;
    if (bx > hi) hi = bx;
    if (cx > hi) hi = cx;
    if (cy == ay) begin
      bx_o = lo;
      cx_o = hi;
    end else begin
      bx_o = bx;
      cx_o = cx;
    end
  end

  assign task_data_o = {in_q[3 * VW +: COLOUR_BITS], cy, by, ay, cx_o, bx_o, ax};

endmodule

// ===== rtl/tsg_queue.sv =====
// ----------------------------------------------------------------------------
// Triangle span generator queue
// Short first-in first-out buffer of sorted triangles between the front
// end and the edge walker.
// ----------------------------------------------------------------------------
module tsg_queue
  import tsg_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output q_status_t        status_o
);

  logic [WIDTH-1:0]   mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/tsg_walker.sv =====
// ----------------------------------------------------------------------------
// Triangle span generator edge walker
// Walks the short and long edges of one sorted triangle row by row with
// Bresenham error terms and issues one span per row into an output register.
// ----------------------------------------------------------------------------
module tsg_walker
  import tsg_pkg::*;
#(
  parameter int unsigned X_BITS  = X_BITS_DEF,
  localparam int unsigned TASK_W = 3 * X_BITS + 3 * ROW_BITS + COLOUR_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   task_valid_i,
  input  logic [TASK_W-1:0]      task_data_i,
  output logic                   task_pop_o,
  output logic                   span_valid_o,
  input  logic                   span_ready_i,
  output logic [X_BITS-1:0]      span_xa_o,
  output logic [X_BITS-1:0]      span_xb_o,
  output logic [ROW_BITS-1:0]    span_row_o,
  output logic [COLOUR_BITS-1:0] span_colour_o,
  output logic                   span_last_o
);

  // The error term stays below the sum of the two deltas.
  localparam int unsigned ERR_W = ((X_BITS > ROW_BITS) ? X_BITS : ROW_BITS) + 1;

  walk_state_e state_q, state_d;

  logic [X_BITS-1:0]      ax_q, bx_q, cx_q;
  logic [ROW_BITS-1:0]    ay_q, by_q, cy_q, y_q;
  logic [COLOUR_BITS-1:0] colour_q;
  logic                   phase_bot_q;

  // Short edge (AB, then BC) and long edge (AC).
  logic [X_BITS-1:0]   s_x_q, s_adx_q, l_x_q, l_adx_q;
  logic [ERR_W-1:0]    s_err_q, l_err_q;
  logic [ROW_BITS-1:0] s_ady_q, l_ady_q;
  logic                s_neg_q, l_neg_q, s_done_q, l_done_q;
  logic                s_stepping, l_stepping, s_finish, l_finish, all_done;

  logic out_valid_q, out_free, span_is_last;
  logic ld_setup, ld_bc, emit_span, emit_final, step_en;

  function automatic logic [X_BITS-1:0] abs_diff(input logic [X_BITS-1:0] a,
                                                 input logic [X_BITS-1:0] b);
    return (b >= a) ? (b - a) : (a - b);
  endfunction

  // Per-edge step decision: move x while the error is below |dx|, otherwise
  // take |dx| off once and the edge has reached the next row.
  assign s_stepping = !s_done_q && (s_ady_q != '0) && (s_err_q < ERR_W'(s_adx_q));
  assign l_stepping = !l_done_q && (l_ady_q != '0) && (l_err_q < ERR_W'(l_adx_q));
  assign s_finish   = !s_done_q && !s_stepping;
  assign l_finish   = !l_done_q && !l_stepping;
  assign all_done   = (s_done_q || s_finish) && (l_done_q || l_finish);

  assign out_free     = !out_valid_q || span_ready_i;
  assign span_is_last = phase_bot_q && (y_q == cy_q);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_d    = state_q;
    task_pop_o = 1'b0;
    ld_setup   = 1'b0;
    ld_bc      = 1'b0;
    emit_span  = 1'b0;
    emit_final = 1'b0;
    step_en    = 1'b0;
    case (state_q)
      WS_IDLE: begin
        if (task_valid_i) begin
          task_pop_o = 1'b1;
          state_d    = WS_SETUP;
        end
      end
      WS_SETUP: begin
        ld_setup = 1'b1;
        state_d  = WS_CHECK;
      end
      WS_CHECK: begin
        if (y_q < by_q) begin
          state_d = WS_EMIT;
        end else if (cy_q == by_q) begin
          state_d = WS_FINAL;
        end else begin
          ld_bc   = 1'b1;
          state_d = WS_EMIT;
        end
      end
      WS_EMIT: begin
        if (out_free) begin
          emit_span = 1'b1;
          state_d   = span_is_last ? WS_IDLE : WS_STEP;
        end
      end
      WS_STEP: begin
        step_en = 1'b1;
        if (all_done) begin
          state_d = phase_bot_q ? WS_EMIT : WS_CHECK;
        end
      end
      WS_FINAL: begin
        if (out_free) begin
          emit_final = 1'b1;
          state_d    = WS_IDLE;
        end
      end
      default: begin
        state_d = WS_IDLE;
      end
    endcase
  end

  // Triangle latch, taken as the queue entry is popped.
  always_ff @(posedge clk_i) begin
    if (task_pop_o) begin
      ax_q     <= task_data_i[0 +: X_BITS];
      bx_q     <= task_data_i[X_BITS +: X_BITS];
      cx_q     <= task_data_i[2 * X_BITS +: X_BITS];
      ay_q     <= task_data_i[3 * X_BITS +: ROW_BITS];
      by_q     <= task_data_i[3 * X_BITS + ROW_BITS +: ROW_BITS];
      cy_q     <= task_data_i[3 * X_BITS + 2 * ROW_BITS +: ROW_BITS];
      colour_q <= task_data_i[3 * X_BITS + 3 * ROW_BITS +: COLOUR_BITS];
    end
  end

  // Row counter and half select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_bot_q <= 1'b0;
      y_q         <= '0;
    end else if (ld_setup) begin
      phase_bot_q <= 1'b0;
      y_q         <= ay_q;
    end else begin
      if (ld_bc) begin
        phase_bot_q <= 1'b1;
      end
      if (step_en && all_done) begin
        y_q <= y_q + 1'b1;
      end
    end
  end

  // Short edge: AB for the upper half, BC for the lower half.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_done_q <= 1'b0;
    end else if (ld_setup || ld_bc) begin
      s_done_q <= 1'b0;
    end else if (step_en) begin
      s_done_q <= all_done ? 1'b0 : (s_done_q || s_finish);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_setup) begin
      s_x_q   <= ax_q;
      s_adx_q <= abs_diff(ax_q, bx_q);
      s_ady_q <= by_q - ay_q;
      s_neg_q <= (bx_q < ax_q);
      s_err_q <= ERR_W'((by_q - ay_q) >> 1);
    end else if (ld_bc) begin
      s_x_q   <= bx_q;
      s_adx_q <= abs_diff(bx_q, cx_q);
      s_ady_q <= cy_q - by_q;
      s_neg_q <= (cx_q < bx_q);
      s_err_q <= ERR_W'((cy_q - by_q) >> 1);
    end else if (step_en) begin
      if (s_stepping) begin
        s_x_q   <= s_neg_q ? (s_x_q - 1'b1) : (s_x_q + 1'b1);
        s_err_q <= s_err_q + ERR_W'(s_ady_q);
      end else if (s_finish && (s_ady_q != '0)) begin
        s_err_q <= s_err_q - ERR_W'(s_adx_q);
      end
    end
  end

  // Long edge AC, walked over the whole triangle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_done_q <= 1'b0;
    end else if (ld_setup) begin
      l_done_q <= 1'b0;
    end else if (step_en) begin
      l_done_q <= all_done ? 1'b0 : (l_done_q || l_finish);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_setup) begin
      l_x_q   <= ax_q;
      l_adx_q <= abs_diff(ax_q, cx_q);
      l_ady_q <= cy_q - ay_q;
      l_neg_q <= (cx_q < ax_q);
      l_err_q <= ERR_W'((cy_q - ay_q) >> 1);
    end else if (step_en) begin
      if (l_stepping) begin
        l_x_q   <= l_neg_q ? (l_x_q - 1'b1) : (l_x_q + 1'b1);
        l_err_q <= l_err_q + ERR_W'(l_ady_q);
      end else if (l_finish && (l_ady_q != '0)) begin
        l_err_q <= l_err_q - ERR_W'(l_adx_q);
      end
    end
  end

  // Output register; the walker moves on while a span waits to be taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_span || emit_final) begin
      out_valid_q <= 1'b1;
    end else if (span_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_span) begin
      span_xa_o     <= s_x_q;
      span_xb_o     <= l_x_q;
      span_row_o    <= y_q;
      span_colour_o <= colour_q;
      span_last_o   <= span_is_last;
    end else if (emit_final) begin
      span_xa_o     <= bx_q;
      span_xb_o     <= cx_q;
      span_row_o    <= y_q;
      span_colour_o <= colour_q;
      span_last_o   <= 1'b1;
    end
  end

  assign span_valid_o = out_valid_q;

endmodule

// ===== rtl/triangle_span_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Triangle span generator
// Takes one triangle per input transfer and returns one horizontal span per
// tile row it covers, the final span flagged on tlast. A triangle starts with
// its pop from the queue, the edge set-up and a row check against the middle
// vertex; then each row issues its span and advances both edges until each
// reaches the next row, the edge walker moving x by one pixel per cycle. Rows
// above the middle vertex also pass the check state, and the final row needs
// no edge advance. Output stalls lengthen the walk; the front end and a
// two-entry queue take further triangles meanwhile.
// ----------------------------------------------------------------------------
`include "triangle_span_generator_unit_defines.svh"

module triangle_span_generator_unit
  import tsg_pkg::*;
#(
  parameter int unsigned X_BITS       = X_BITS_DEF,
  parameter int unsigned TILE_ROWS    = TILE_ROWS_DEF,
  localparam int unsigned IN_W        = 3 * (X_BITS + ROW_BITS) + COLOUR_BITS,
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W       = 2 * X_BITS + ROW_BITS + COLOUR_BITS,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // vx0, vy0, vx1, vy1, vx2, vy2, colour; zero padding above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // span_xa, span_xb, span_row, span_colour; zero padding above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // last_span
  output logic                   m_axis_tlast
);

  localparam int unsigned TASK_W = 3 * X_BITS + 3 * ROW_BITS + COLOUR_BITS;

  logic              front_valid, q_push, q_pop;
  logic [TASK_W-1:0] front_task, q_task;
  q_status_t         q_stat;

  logic [X_BITS-1:0]      span_xa, span_xb;
  logic [ROW_BITS-1:0]    span_row;
  logic [COLOUR_BITS-1:0] span_colour;

  // Front end: clamp, sort and classify.
  tsg_front #(
    .X_BITS    (X_BITS),
    .TILE_ROWS (TILE_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata[IN_W-1:0]),
    .task_valid_o (front_valid),
    .task_ready_i (!q_stat.full),
    .task_data_o  (front_task)
  );

  assign q_push = front_valid && !q_stat.full;

  // Sorted triangles waiting for the walker.
  tsg_queue #(
    .WIDTH (TASK_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_task),
    .pop_i       (q_pop),
    .pop_data_o  (q_task),
    .status_o    (q_stat)
  );

  // Back end: edge walking and span issue.
  tsg_walker #(
    .X_BITS (X_BITS)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .task_valid_i  (!q_stat.empty),
    .task_data_i   (q_task),
    .task_pop_o    (q_pop),
    .span_valid_o  (m_axis_tvalid),
    .span_ready_i  (m_axis_tready),
    .span_xa_o     (span_xa),
    .span_xb_o     (span_xb),
    .span_row_o    (span_row),
    .span_colour_o (span_colour),
    .span_last_o   (m_axis_tlast)
  );

  // Pack the span fields, lowest field first.
  assign m_axis_tdata = OUT_TDATA_W'({span_colour, span_row, span_xb, span_xa});

  // Checks on the queue hand-over and the span rows.
  `TSG_ASSERT_NOW(a_pop_not_empty, clk_i, rst_ni, q_pop, !q_stat.empty, "pop from empty queue")
  `TSG_ASSERT_NOW(a_queue_status, clk_i, rst_ni, 1'b1, !(q_stat.full && q_stat.empty), "queue status inconsistent")
  `TSG_ASSERT_NEXT(a_queue_fills, clk_i, rst_ni, q_push && !q_pop && !q_stat.empty, q_stat.full, "queue count lost a push")
  `TSG_ASSERT_NOW(a_row_in_tile, clk_i, rst_ni, m_axis_tvalid, span_row <= ROW_BITS'(TILE_ROWS - 1), "span row outside tile")

endmodule
